FILE: hdl/xrng_pkg.sv
package xrng_pkg;

   localparam int unsigned COUNT_W = 10;
   localparam logic [COUNT_W-1:0] MAX_REQUEST_BYTES = 10'd512;
   localparam logic [COUNT_W-1:0] WORD_BYTES = 10'd8;

   localparam logic [63:0] GOLDEN_INC    = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_MUL_A     = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_MUL_B     = 64'h94D0_49BB_1331_11EB;
   localparam logic [63:0] ZERO_SEED_SUB = 64'h1234_5678_9ABC_DEF0;
   localparam logic [63:0] FALLBACK_W0   = 64'h1234_5678_9ABC_DEF0;
   localparam logic [63:0] FALLBACK_W1   = 64'h0FED_CBA9_8765_4321;
   localparam logic [63:0] FALLBACK_W2   = 64'h5A5A_5A5A_5A5A_5A5A;
   localparam logic [63:0] FALLBACK_W3   = 64'hA5A5_A5A5_A5A5_A5A5;

   typedef logic [3:0] op_type;

   // datapath operations
   localparam op_type OP_NONE     = 4'd0;
   localparam op_type OP_SEED     = 4'd1;   // load splitmix accumulator
   localparam op_type OP_ADD      = 4'd2;   // acc += golden, first xor-shift
   localparam op_type OP_MUL_LO   = 4'd3;   // prod = zl * cl
   localparam op_type OP_MUL_HI_A = 4'd4;   // prod.hi += zh * cl
   localparam op_type OP_MUL_HI_B = 4'd5;   // prod.hi += zl * ch
   localparam op_type OP_FOLD     = 4'd6;   // z = prod ^ (prod >> 27)
   localparam op_type OP_STORE    = 4'd7;   // state word = prod ^ (prod >> 31)
   localparam op_type OP_FIX      = 4'd8;   // all-zero state fallback

   typedef struct packed {
      op_type     op;
      logic       mul_sel_b;
      logic [1:0] word_idx;
      logic       load_req;
      logic       issue;
   } cmd_type;

   typedef struct packed {
      logic rem_zero;
      logic rem_last;
      logic pipe_adv;
   } status_type;

endpackage

FILE: hdl/xoshiro256ss_random_generator_core.sv
// xoshiro256** random byte source. A request word asks for up to 512 bytes
// (larger counts are clipped to 512, zero gives no result words). Results
// come back as 64-bit generator words, byte 0 in the low bits, with a count
// of valid bytes that is 8 except possibly on the final word, which carries
// tlast. The first request after reset seeds the four state words from the
// seed register through four splitmix64 steps; this seeding runs on the
// single 32x32 multiplier, which builds each 64-bit product in three
// passes. After that the block issues one word per cycle through a
// two-stage output pipeline while the consumer keeps tready high; a stall
// holds the pipeline. The seed is only read at that first request; writes
// after seeding have no effect, as reset clears the seed register to zero.
module xoshiro256ss_random_generator_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [9:0] byte_count, rest zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // [63:0] random_word, [67:64] valid_bytes
   output logic        rsp_tlast,    // last_word
   // seed register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data      // seed_value
);
   import xrng_pkg::*;

   cmd_type    cmd;
   status_type status;

   // seed register takes a write every cycle
   assign csr_ready = 1'b1;

   xrng_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   xrng_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: hdl/xrng_datapath.sv
module xrng_datapath (
   input  logic                clock,
   input  logic                reset,
   input  xrng_pkg::cmd_type   cmd,
   output xrng_pkg::status_type status,
   input  logic [15:0]         req_tdata,
   input  logic                csr_valid,
   input  logic [63:0]         csr_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [71:0]         rsp_tdata,
   output logic                rsp_tlast
);
   import xrng_pkg::*;

   logic [63:0] seed_ff, seed_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] z_ff, z_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] w_ff [4];
   logic [63:0] w_in [4];
   logic [COUNT_W-1:0] rem_ff, rem_in;

   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] s1_mix_ff, s1_mix_in;
   logic [3:0]  s1_bytes_ff, s1_bytes_in;
   logic        s1_last_ff, s1_last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_word_ff, rsp_word_in;
   logic [3:0]  rsp_bytes_ff, rsp_bytes_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_const, mul_p, acc_sum, w1_x5, t17;
   logic [COUNT_W-1:0] req_count;
   logic [3:0]  take;
   logic        adv, rem_last;

   assign adv       = !rsp_valid_ff || rsp_tready;
   assign rem_last  = rem_ff <= WORD_BYTES;
   assign take      = rem_last ? rem_ff[3:0] : WORD_BYTES[3:0];
   assign req_count = (req_tdata[COUNT_W-1:0] > MAX_REQUEST_BYTES) ?
                      MAX_REQUEST_BYTES : req_tdata[COUNT_W-1:0];

   assign status.rem_zero = rem_ff == '0;
   assign status.rem_last = rem_last;
   assign status.pipe_adv = adv;

   // one shared 32x32 multiplier, products mod 2^64 built from three partial products
   assign mul_const = cmd.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;
   assign mul_a     = (cmd.op == OP_MUL_HI_A) ? z_ff[63:32] : z_ff[31:0];
   assign mul_b     = (cmd.op == OP_MUL_HI_B) ? mul_const[63:32] : mul_const[31:0];
   assign mul_p     = {32'b0, mul_a} * {32'b0, mul_b};
   assign acc_sum   = acc_ff + GOLDEN_INC;

   assign w1_x5 = w_ff[1] + {w_ff[1][61:0], 2'b00};
   assign t17   = {w_ff[1][46:0], 17'b0};

   always_comb begin
      seed_in = csr_valid ? csr_data : seed_ff;
      acc_in  = acc_ff;
      z_in    = z_ff;
      prod_in = prod_ff;
      for (int i = 0; i < 4; i++) w_in[i] = w_ff[i];
      case (cmd.op)
         OP_SEED: begin
            acc_in = (seed_ff == '0) ? ZERO_SEED_SUB : seed_ff;
         end
         OP_ADD: begin
            acc_in = acc_sum;
            z_in   = acc_sum ^ (acc_sum >> 30);
         end
         OP_MUL_LO: begin
            prod_in = mul_p;
         end
         OP_MUL_HI_A, OP_MUL_HI_B: begin
            prod_in[63:32] = prod_ff[63:32] + mul_p[31:0];
         end
         OP_FOLD: begin
            z_in = prod_ff ^ (prod_ff >> 27);
         end
         OP_STORE: begin
            w_in[cmd.word_idx] = prod_ff ^ (prod_ff >> 31);
         end
         OP_FIX: begin
            if ((w_ff[0] | w_ff[1] | w_ff[2] | w_ff[3]) == '0) begin
               w_in[0] = FALLBACK_W0;
               w_in[1] = FALLBACK_W1;
               w_in[2] = FALLBACK_W2;
               w_in[3] = FALLBACK_W3;
            end
         end
         default: begin
         end
      endcase
      if (cmd.issue) begin
         w_in[2] = w_ff[2] ^ w_ff[0];
         w_in[3] = w_ff[3] ^ w_ff[1];
         w_in[1] = w_ff[1] ^ w_ff[2] ^ w_ff[0];
         w_in[0] = w_ff[0] ^ w_ff[3] ^ w_ff[1];
         w_in[2] = w_ff[2] ^ w_ff[0] ^ t17;
         w_in[3] = {w_in[3][18:0], w_in[3][63:19]};
      end
   end

   always_comb begin
      rem_in       = rem_ff;
      s1_valid_in  = s1_valid_ff;
      s1_mix_in    = s1_mix_ff;
      s1_bytes_in  = s1_bytes_ff;
      s1_last_in   = s1_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load_req) begin
         rem_in = req_count;
      end
      if (adv) begin
         rsp_valid_in = s1_valid_ff;
         rsp_word_in  = s1_mix_ff + {s1_mix_ff[60:0], 3'b000};
         rsp_bytes_in = s1_bytes_ff;
         rsp_last_in  = s1_last_ff;
         s1_valid_in  = cmd.issue;
      end
      if (cmd.issue) begin
         s1_mix_in   = {w1_x5[56:0], w1_x5[63:57]};
         s1_bytes_in = take;
         s1_last_in  = rem_last;
         rem_in      = rem_ff - {{(COUNT_W-4){1'b0}}, take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         seed_ff      <= seed_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      z_ff         <= z_in;
      prod_ff      <= prod_in;
      for (int i = 0; i < 4; i++) w_ff[i] <= w_in[i];
      s1_mix_ff    <= s1_mix_in;
      s1_bytes_ff  <= s1_bytes_in;
      s1_last_ff   <= s1_last_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_bytes_ff, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/xrng_ctrl.sv
module xrng_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  xrng_pkg::status_type status,
   output xrng_pkg::cmd_type    cmd
);
   import xrng_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SEED      = 4'd1;
   localparam logic [3:0] S_ADD       = 4'd2;
   localparam logic [3:0] S_MUL_LO    = 4'd3;
   localparam logic [3:0] S_MUL_HI_A  = 4'd4;
   localparam logic [3:0] S_MUL_HI_B  = 4'd5;
   localparam logic [3:0] S_FOLD      = 4'd6;
   localparam logic [3:0] S_STORE     = 4'd7;
   localparam logic [3:0] S_FIX       = 4'd8;
   localparam logic [3:0] S_GEN       = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       seeded_ff, seeded_in;
   logic       phase_ff, phase_in;    // 0: first multiply, 1: second
   logic [1:0] idx_ff, idx_in;

   always_comb begin
      state_in      = state_ff;
      seeded_in     = seeded_ff;
      phase_in      = phase_ff;
      idx_in        = idx_ff;
      cmd.op        = OP_NONE;
      cmd.mul_sel_b = phase_ff;
      cmd.word_idx  = idx_ff;
      cmd.load_req  = 1'b0;
      cmd.issue     = 1'b0;
      req_tready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in = seeded_ff ? S_GEN : S_SEED;
            end
         end
         S_SEED: begin
            cmd.op   = OP_SEED;
            idx_in   = 2'd0;
            phase_in = 1'b0;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.op   = OP_ADD;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.op   = OP_MUL_LO;
            state_in = S_MUL_HI_A;
         end
         S_MUL_HI_A: begin
            cmd.op   = OP_MUL_HI_A;
            state_in = S_MUL_HI_B;
         end
         S_MUL_HI_B: begin
            cmd.op   = OP_MUL_HI_B;
            state_in = phase_ff ? S_STORE : S_FOLD;
         end
         S_FOLD: begin
            cmd.op   = OP_FOLD;
            phase_in = 1'b1;
            state_in = S_MUL_LO;
         end
         S_STORE: begin
            cmd.op   = OP_STORE;
            phase_in = 1'b0;
            idx_in   = idx_ff + 2'd1;
            state_in = (idx_ff == 2'd3) ? S_FIX : S_ADD;
         end
         S_FIX: begin
            cmd.op    = OP_FIX;
            seeded_in = 1'b1;
            state_in  = S_GEN;
         end
         S_GEN: begin
            if (status.rem_zero) begin
               state_in = S_IDLE;
            end else if (status.pipe_adv) begin
               cmd.issue = 1'b1;
               if (status.rem_last) state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         seeded_ff <= 1'b0;
         phase_ff  <= 1'b0;
         idx_ff    <= 2'd0;
      end else begin
         state_ff  <= state_in;
         seeded_ff <= seeded_in;
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
      end
   end

endmodule

FILE: hdl/xrng_checker.sv
module xrng_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // byte count always 1 to 8, padding zero
   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[67:64] != 4'd0 && rsp_tdata[67:64] <= 4'd8
                     && rsp_tdata[71:68] == 4'd0)
      else $error("valid byte count out of range");

   // only the final word of a request may be short
   a_full_words: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[67:64] == 4'd8)
      else $error("short word without last flag");

   // out of reset the block is idle and ready for a request
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule

bind xoshiro256ss_random_generator_core xrng_checker u_xrng_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
